### rtl/scr_pkg.sv
// Shared types and constants for the sidelink control resource selection block.
`default_nettype none
package scr_pkg;
	localparam int BITMAP_BITS_DEF = 40;
	localparam int FRM_W   = 10;
	localparam int SUB_W   = 4;
	localparam int OFS_W   = 14;
	localparam int PLEN_W  = 9;
	localparam int MAP_W   = 40;
	localparam int RES_W   = 16;
	localparam int RB_W    = 7;
	localparam int POS_W   = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 40;
	localparam int DVD_W   = 17;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam logic [OFS_W-1:0] SF_PER_FRAME = 14'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERIOD_OFFSET = 3'd0,
		REG_PERIOD_LENGTH = 3'd1,
		REG_SUBFRAME_MAP  = 3'd2,
		REG_RESOURCE_NUM  = 3'd3,
		REG_RB_PER_REGION = 3'd4,
		REG_REGION_START  = 3'd5,
		REG_REGION_END    = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic             skip;
		logic [OFS_W-1:0] diff;
	} q_item_t;

	typedef struct packed {
		logic [PLEN_W-1:0] plen;
		logic              err;
		logic [POS_W-1:0]  pos_b1;
		logic [POS_W-1:0]  pos_b2;
		logic [RES_W-1:0]  a1;
		logic [RES_W-1:0]  a2;
		logic [RB_W-1:0]   prb1;
		logic [RB_W-1:0]   prb2;
	} derived_t;
endpackage
`default_nettype wire

### rtl/scr_cfg.sv
// Configuration registers and the sequencer that derives L, b1, b2, a1 and positions.
`default_nettype none
module scr_cfg #(
	parameter int BITMAP_BITS = scr_pkg::BITMAP_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [scr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [scr_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic      [scr_pkg::OFS_W-1:0]        offset,
	output logic      [BITMAP_BITS-1:0]           map_w,
	output scr_pkg::derived_t                     drv,
	output logic                                  busy
);
	localparam int LW = $clog2(BITMAP_BITS + 1);
	localparam int IW = $clog2(BITMAP_BITS);
	localparam logic [IW-1:0] LAST_IDX = IW'(BITMAP_BITS - 1);
	localparam logic [4:0] LAST_STEP = 5'(scr_pkg::DVD_W - 1);

	typedef enum logic [2:0] {ST_IDLE, ST_COUNT, ST_DIV1, ST_DIV2, ST_DIV3, ST_SCAN} state_t;

	state_t state_q;
	logic [scr_pkg::OFS_W-1:0]  offset_q;
	logic [scr_pkg::PLEN_W-1:0] plen_q;
	logic [scr_pkg::MAP_W-1:0]  bitmap_q;
	logic [scr_pkg::RES_W-1:0]  resnum_q;
	logic [scr_pkg::RB_W-1:0]   nrb_q, start_q, end_q;
	logic [IW-1:0]              idx_q, pb1_q, pb2_q;
	logic [LW-1:0]              l_q, rem_q, div_d_q, rank_q, b1_q, b2_q;
	logic [scr_pkg::DVD_W-1:0]  dvd_q;
	logic [4:0]                 step_q;
	logic [scr_pkg::RES_W-1:0]  a1_q;
	logic                       err_q;

	logic                       bit_now;
	logic [LW-1:0]              l_fin;
	logic [scr_pkg::RB_W+LW-1:0] prod;
	logic [LW:0]                t;
	logic                       ge;
	logic [LW-1:0]              rem_nx;
	logic [scr_pkg::DVD_W-1:0]  dvd_nx;
	logic [scr_pkg::DVD_W-1:0]  a2_full;

	assign map_w   = BITMAP_BITS'(bitmap_q);
	assign bit_now = map_w[idx_q];
	assign l_fin   = l_q + LW'(bit_now);
	assign prod    = nrb_q * l_fin;

	// one restoring division step
	assign t      = {rem_q, dvd_q[scr_pkg::DVD_W-1]};
	assign ge     = t >= {1'b0, div_d_q};
	assign rem_nx = ge ? LW'(t - {1'b0, div_d_q}) : t[LW-1:0];
	assign dvd_nx = {dvd_q[scr_pkg::DVD_W-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			offset_q <= '0;
			plen_q   <= 9'd40;
			bitmap_q <= '0;
			resnum_q <= '0;
			nrb_q    <= 7'd1;
			start_q  <= '0;
			end_q    <= '0;
			idx_q    <= '0;
			l_q      <= '0;
			rem_q    <= '0;
			div_d_q  <= '0;
			dvd_q    <= '0;
			step_q   <= '0;
			rank_q   <= '0;
			b1_q     <= '0;
			b2_q     <= '0;
			a1_q     <= '0;
			pb1_q    <= '0;
			pb2_q    <= '0;
			err_q    <= 1'b1;
		end else if (cfg_we) begin
			case (scr_pkg::cfg_reg_t'(cfg_index))
				scr_pkg::REG_PERIOD_OFFSET: offset_q <= cfg_data[scr_pkg::OFS_W-1:0];
				scr_pkg::REG_PERIOD_LENGTH: plen_q   <= cfg_data[scr_pkg::PLEN_W-1:0];
				scr_pkg::REG_SUBFRAME_MAP:  bitmap_q <= cfg_data[scr_pkg::MAP_W-1:0];
				scr_pkg::REG_RESOURCE_NUM:  resnum_q <= cfg_data[scr_pkg::RES_W-1:0];
				scr_pkg::REG_RB_PER_REGION: nrb_q    <= cfg_data[scr_pkg::RB_W-1:0];
				scr_pkg::REG_REGION_START:  start_q  <= cfg_data[scr_pkg::RB_W-1:0];
				scr_pkg::REG_REGION_END:    end_q    <= cfg_data[scr_pkg::RB_W-1:0];
				default: ;
			endcase
			state_q <= ST_COUNT;
			idx_q   <= '0;
			l_q     <= '0;
		end else begin
			case (state_q)
				ST_COUNT: begin
					l_q <= l_fin;
					if (idx_q == LAST_IDX) begin
						err_q   <= (l_fin < LW'(2)) ||
						           (scr_pkg::DVD_W'(resnum_q) >= scr_pkg::DVD_W'(prod));
						state_q <= ST_DIV1;
						dvd_q   <= scr_pkg::DVD_W'(resnum_q);
						div_d_q <= l_fin;
						rem_q   <= '0;
						step_q  <= '0;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_DIV1, ST_DIV2, ST_DIV3: begin
					if (step_q == LAST_STEP) begin
						step_q <= '0;
						rem_q  <= '0;
						if (state_q == ST_DIV1) begin
							a1_q    <= dvd_nx[scr_pkg::RES_W-1:0];
							b1_q    <= rem_nx;
							dvd_q   <= {1'b0, dvd_nx[scr_pkg::RES_W-1:0]};
							div_d_q <= l_q - LW'(1);
							state_q <= ST_DIV2;
						end else if (state_q == ST_DIV2) begin
							dvd_q   <= scr_pkg::DVD_W'(resnum_q) + scr_pkg::DVD_W'(1)
							           + scr_pkg::DVD_W'(rem_nx);
							div_d_q <= l_q;
							state_q <= ST_DIV3;
						end else begin
							b2_q    <= rem_nx;
							idx_q   <= '0;
							rank_q  <= '0;
							state_q <= ST_SCAN;
						end
					end else begin
						step_q <= step_q + 5'd1;
						rem_q  <= rem_nx;
						dvd_q  <= dvd_nx;
					end
				end
				ST_SCAN: begin
					if (bit_now) begin
						if (rank_q == b1_q) pb1_q <= idx_q;
						if (rank_q == b2_q) pb2_q <= idx_q;
						rank_q <= rank_q + LW'(1);
					end
					if (idx_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign a2_full = scr_pkg::DVD_W'(a1_q) + scr_pkg::DVD_W'(nrb_q);

	always_comb begin
		drv.plen   = plen_q;
		drv.err    = err_q;
		drv.pos_b1 = scr_pkg::POS_W'(pb1_q);
		drv.pos_b2 = scr_pkg::POS_W'(pb2_q);
		drv.a1     = a1_q;
		drv.a2     = a2_full[scr_pkg::RES_W] ? '1 : a2_full[scr_pkg::RES_W-1:0];
		drv.prb1   = start_q + a1_q[scr_pkg::RB_W-1:0];
		drv.prb2   = end_q + 7'd1 + a1_q[scr_pkg::RB_W-1:0] - nrb_q;
	end

	assign offset = offset_q;
	assign busy   = state_q != ST_IDLE;
endmodule
`default_nettype wire

### rtl/scr_front.sv
// Front end: accepts queries, forms the offset subframe count and classifies skips.
`default_nettype none
module scr_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [scr_pkg::FRM_W-1:0]     frame_number,
	input  wire logic [scr_pkg::SUB_W-1:0]     subframe_number,
	input  wire logic                          already_done,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [scr_pkg::OFS_W-1:0]     offset,
	input  wire logic [scr_pkg::PLEN_W-1:0]    plen,
	input  wire logic                          busy,
	input  wire logic                          fifo_full,
	output logic                               push,
	output scr_pkg::q_item_t                   push_item
);
	logic             valid_s1;
	scr_pkg::q_item_t item_s1;
	scr_pkg::q_item_t cls;
	logic [scr_pkg::OFS_W-1:0] abs_sf;
	logic load_s1;

	assign abs_sf = scr_pkg::OFS_W'(frame_number) * scr_pkg::SF_PER_FRAME
	                + scr_pkg::OFS_W'(subframe_number);

	always_comb begin
		cls.skip = already_done || (abs_sf < offset) || (plen == '0);
		cls.diff = abs_sf - offset;
	end

	assign load_s1  = !valid_s1 || !fifo_full;
	assign in_stall = busy || !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid && !in_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) item_s1 <= cls;
	end

	assign push      = valid_s1 && !fifo_full;
	assign push_item = item_s1;
endmodule
`default_nettype wire

### rtl/scr_fifo.sv
// Short queue between the front end and the back end.
`default_nettype none
module scr_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire scr_pkg::q_item_t push_item,
	input  wire logic             pop,
	output scr_pkg::q_item_t      head,
	output logic                  empty,
	output logic                  full
);
	scr_pkg::q_item_t mem_q [scr_pkg::FIFO_DEPTH];
	logic [scr_pkg::FIFO_PTR_W-1:0] wr_q, rd_q;
	logic [scr_pkg::FIFO_PTR_W:0]   cnt_q;

	assign empty = cnt_q == '0;
	assign full  = cnt_q == (scr_pkg::FIFO_PTR_W+1)'(scr_pkg::FIFO_DEPTH);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + scr_pkg::FIFO_PTR_W'(1);
			if (pop)  rd_q <= rd_q + scr_pkg::FIFO_PTR_W'(1);
			if (push && !pop) cnt_q <= cnt_q + (scr_pkg::FIFO_PTR_W+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (scr_pkg::FIFO_PTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end
endmodule
`default_nettype wire

### rtl/scr_back.sv
// Back end: pipelined modulo by the period, bitmap test and slot match.
`default_nettype none
module scr_back #(
	parameter int BITMAP_BITS = scr_pkg::BITMAP_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        empty,
	input  wire scr_pkg::q_item_t            head,
	output logic                             pop,
	input  wire scr_pkg::derived_t           drv,
	input  wire logic [BITMAP_BITS-1:0]      map_w,
	input  wire logic                        out_stall,
	output logic                             out_valid,
	output logic                             selected,
	output logic                             slot_index,
	output logic [scr_pkg::RES_W-1:0]        resource_index,
	output logic [scr_pkg::RB_W-1:0]         prb_number,
	output logic                             config_error
);
	localparam int NS = scr_pkg::OFS_W;
	localparam int IW = $clog2(BITMAP_BITS);
	localparam int RW = scr_pkg::PLEN_W;

	logic                       stg_valid_s [NS];
	logic                       stg_skip_s  [NS];
	logic [scr_pkg::OFS_W-1:0]  stg_dvd_s   [NS];
	logic [RW-1:0]              stg_rem_s   [NS];

	logic adv;
	logic out_valid_q, sel_q, slot_q, err_q;
	logic [scr_pkg::RES_W-1:0] res_q;
	logic [scr_pkg::RB_W-1:0]  prb_q;

	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && !empty;

	function automatic logic [RW-1:0] mod_step(input logic [RW-1:0] r, input logic b,
	                                          input logic [RW-1:0] d);
		logic [RW:0] t;
		t = {r, b};
		mod_step = (t >= {1'b0, d}) ? RW'(t - {1'b0, d}) : t[RW-1:0];
	endfunction

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic                      v_in, skip_in;
		logic [scr_pkg::OFS_W-1:0] dvd_in;
		logic [RW-1:0]             rem_in;
		if (k == 0) begin : g_first
			assign v_in    = !empty;
			assign skip_in = head.skip;
			assign dvd_in  = head.diff;
			assign rem_in  = '0;
		end else begin : g_next
			assign v_in    = stg_valid_s[k-1];
			assign skip_in = stg_skip_s[k-1];
			assign dvd_in  = stg_dvd_s[k-1];
			assign rem_in  = stg_rem_s[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stg_valid_s[k] <= 1'b0;
			end else if (adv) begin
				stg_valid_s[k] <= v_in;
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				stg_skip_s[k] <= skip_in;
				stg_dvd_s[k]  <= {dvd_in[scr_pkg::OFS_W-2:0], 1'b0};
				stg_rem_s[k]  <= mod_step(rem_in, dvd_in[scr_pkg::OFS_W-1], drv.plen);
			end
		end
	end

	logic [scr_pkg::POS_W-1:0] pos;
	logic in_map;
	assign pos    = stg_rem_s[NS-1];
	assign in_map = (pos < scr_pkg::POS_W'(BITMAP_BITS)) && map_w[pos[IW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= stg_valid_s[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sel_q  <= 1'b0;
			slot_q <= 1'b0;
			res_q  <= '0;
			prb_q  <= '0;
			err_q  <= 1'b0;
			if (!stg_skip_s[NS-1] && in_map) begin
				if (drv.err) begin
					err_q <= 1'b1;
				end else if (pos == drv.pos_b1) begin
					sel_q <= 1'b1;
					res_q <= drv.a1;
					prb_q <= drv.prb1;
				end else if (pos == drv.pos_b2) begin
					sel_q  <= 1'b1;
					slot_q <= 1'b1;
					res_q  <= drv.a2;
					prb_q  <= drv.prb2;
				end
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign selected       = sel_q;
	assign slot_index     = slot_q;
	assign resource_index = res_q;
	assign prb_number     = prb_q;
	assign config_error   = err_q;
endmodule
`default_nettype wire

### rtl/sidelink_control_resource_select.sv
// Top level of the sidelink control subframe and resource selection block.
// From input transaction to result: front stage, queue, 14 modulo stages, output register;
// throughput one query per cycle (one-bit-per-stage modulo pipe) while not stalled.
// After any config write, a sequencer runs the bitmap count, three 17-step divisions
// and the bitmap scan with in_stall held high.
// Reset is asynchronous, active low; registers take their documented defaults.
`default_nettype none
module sidelink_control_resource_select #(
	parameter int BITMAP_BITS = scr_pkg::BITMAP_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [scr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [scr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [scr_pkg::FRM_W-1:0]       frame_number,
	input  wire logic [scr_pkg::SUB_W-1:0]       subframe_number,
	input  wire logic                            already_done,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 selected,
	output logic                                 slot_index,
	output logic [scr_pkg::RES_W-1:0]            resource_index,
	output logic [scr_pkg::RB_W-1:0]             prb_number,
	output logic                                 config_error
);
	logic [scr_pkg::OFS_W-1:0] offset;
	logic [BITMAP_BITS-1:0]    map_w;
	scr_pkg::derived_t         drv;
	logic                      busy, push, pop, empty, full;
	scr_pkg::q_item_t          push_item, head;

	scr_cfg #(.BITMAP_BITS(BITMAP_BITS)) u_cfg (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.offset, .map_w, .drv, .busy
	);

	scr_front u_front (
		.clk, .arst_n, .frame_number, .subframe_number, .already_done,
		.in_valid, .in_stall, .offset, .plen(drv.plen), .busy,
		.fifo_full(full), .push, .push_item
	);

	scr_fifo u_fifo (
		.clk, .arst_n, .push, .push_item, .pop, .head, .empty, .full
	);

	scr_back #(.BITMAP_BITS(BITMAP_BITS)) u_back (
		.clk, .arst_n, .empty, .head, .pop, .drv, .map_w, .out_stall,
		.out_valid, .selected, .slot_index, .resource_index, .prb_number, .config_error
	);

`ifndef SYNTHESIS
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n) busy |-> in_stall)
		else $error("query taken while derived config is being computed");
	a_sel_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(selected && config_error))
		else $error("selection reported together with config error");
	a_unsel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !selected) |-> (resource_index == '0 && prb_number == '0 && !slot_index))
		else $error("unselected result carries nonzero fields");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue written while full");
`endif
endmodule
`default_nettype wire
